// ===== hw/rtl/bbl_pkg.sv =====
// Types and constants shared by the beam-break lap timer.
package bbl_pkg;

  // Timer modes as reported in timer_state.
  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_DISPLAY = 2'd2
  } mode_e;

  // Configuration port geometry and register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_BREAK_THRESHOLD = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LAP         = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN        = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESTORE_STABLE  = 8'd3;

  // Register reset values.
  localparam logic [31:0] BreakThresholdRst = 32'd4000;
  localparam logic [31:0] MinLapRst         = 32'd5000000;
  localparam logic [31:0] CooldownRst       = 32'd5000;
  localparam logic [31:0] RestoreStableRst  = 32'd20000;

  // One poll request.
  typedef struct packed {
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic [31:0] last_pulse_us;
    logic [3:0]  history_index;
  } in_t;

  // One poll result.
  typedef struct packed {
    logic [1:0]  timer_state;
    logic        beam_broken;
    logic        in_progress;
    logic [31:0] live_time_us;
    logic        lap_finished;
    logic [31:0] lap_time_us;
    logic [4:0]  history_count;
    logic [31:0] history_lap_us;
    logic [31:0] history_stamp_ms;
  } out_t;

endpackage

// ===== hw/rtl/beam_break_lap_timer.sv =====
// Beam-break lap timer with a ring history of finished laps.
// Results are registered: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the history
// RAM read is registered, with write-to-read forwarding.
// Reset: timer ready, beam counted as restored, history empty, registers at
// their defaults; the history RAM itself is not cleared and needs no pass.
module beam_break_lap_timer #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bbl_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bbl_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bbl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW  = ((AddrW > 4) ? AddrW : 4) + 1;

  // Configuration registers.
  logic [31:0] break_thr_q, min_lap_q, cooldown_q, restore_stable_q;

  // Scalar timer state.
  bbl_pkg::mode_e mode_q, mode_d, mode_c;
  logic [31:0] lap_start_q, lap_start_d;
  logic [31:0] lap_end_q, lap_end_d;
  logic [31:0] disp_start_q, disp_start_d;
  logic        restored_q, restored_d;
  logic        armed_q, armed_d;
  logic [31:0] restore_start_q, restore_start_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;

  // History RAM: lap in the upper half, stamp in the lower half.
  logic [63:0] hist_mem [HISTORY_DEPTH];
  logic [63:0] rd_q;

  // Output stage.
  logic        out_valid_q;
  logic [1:0]  st_q;
  logic        broken_q, prog_q, fin_q, hit_q;
  logic [31:0] live_q, lap_q;
  logic [4:0]  hcnt_q;

  // Poll datapath.
  logic        accept, advance;
  logic        broken, stop;
  logic [31:0] lap, live;
  logic        wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [63:0] wr_data;
  logic [CntW:0]    oldest_w;
  logic [AddrW-1:0] oldest;
  logic [SumW-1:0]  slot_sum;
  logic        hit;
  logic [31:0] cnt_ext;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !advance;
  assign accept      = in_valid_i && advance;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_thr_q      <= bbl_pkg::BreakThresholdRst;
      min_lap_q        <= bbl_pkg::MinLapRst;
      cooldown_q       <= bbl_pkg::CooldownRst;
      restore_stable_q <= bbl_pkg::RestoreStableRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bbl_pkg::CFG_BREAK_THRESHOLD) break_thr_q <= cfg_data_i;
      if (cfg_index_i == bbl_pkg::CFG_MIN_LAP) min_lap_q <= cfg_data_i;
      if (cfg_index_i == bbl_pkg::CFG_COOLDOWN) cooldown_q <= cfg_data_i;
      if (cfg_index_i == bbl_pkg::CFG_RESTORE_STABLE) restore_stable_q <= cfg_data_i;
    end
  end

  // Cooldown, beam handling, lap completion and live time for one poll.
  always_comb begin
    broken          = (in_data_i.now_us - in_data_i.last_pulse_us) > break_thr_q;
    stop            = 1'b0;
    lap             = '0;
    live            = '0;
    lap_start_d     = lap_start_q;
    lap_end_d       = lap_end_q;
    disp_start_d    = disp_start_q;
    restored_d      = restored_q;
    armed_d         = armed_q;
    restore_start_d = restore_start_q;
    head_d          = head_q;
    count_d         = count_q;

    mode_c = mode_q;
    if (mode_q == bbl_pkg::MODE_DISPLAY &&
        (in_data_i.now_ms - disp_start_q) > cooldown_q) begin
      mode_c = bbl_pkg::MODE_READY;
    end
    mode_d = mode_c;

    if (broken) begin
      if (restored_q) begin
        restored_d = 1'b0;
        armed_d    = 1'b0;
        unique case (mode_c)
          bbl_pkg::MODE_READY: begin
            lap_start_d = in_data_i.now_us;
            mode_d      = bbl_pkg::MODE_RUNNING;
          end
          bbl_pkg::MODE_RUNNING: begin
            if ((in_data_i.now_us - lap_start_q) > min_lap_q) begin
              lap_end_d = in_data_i.now_us;
              stop      = 1'b1;
            end
          end
          default: begin
            // A crossing in display only consumes the restore.
          end
        endcase
      end
    end else if (!restored_q) begin
      if (!armed_q) begin
        armed_d         = 1'b1;
        restore_start_d = in_data_i.now_us;
      end
      if ((in_data_i.now_us - restore_start_d) > restore_stable_q) begin
        restored_d = 1'b1;
        armed_d    = 1'b0;
      end
    end

    // A finished lap enters the history and starts the display.
    if (stop) begin
      lap          = in_data_i.now_us - lap_start_q;
      mode_d       = bbl_pkg::MODE_DISPLAY;
      disp_start_d = in_data_i.now_ms;
      head_d       = (head_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
      if (count_q < CntW'(HISTORY_DEPTH)) count_d = count_q + 1'b1;
    end

    if (mode_d == bbl_pkg::MODE_RUNNING) begin
      live = in_data_i.now_us - lap_start_d;
    end else if (mode_d == bbl_pkg::MODE_DISPLAY) begin
      live = lap_end_d - lap_start_d;
    end
  end

  // History addressing: write at the head, read relative to the oldest entry.
  always_comb begin
    wr_en   = accept && stop;
    wr_addr = head_q;
    wr_data = {lap, in_data_i.now_ms};
    if (CntW'(head_d) >= count_d) begin
      oldest_w = (CntW + 1)'(head_d) - (CntW + 1)'(count_d);
    end else begin
      oldest_w = (CntW + 1)'(head_d) + (CntW + 1)'(HISTORY_DEPTH) - (CntW + 1)'(count_d);
    end
    oldest   = oldest_w[AddrW-1:0];
    slot_sum = SumW'(oldest) + SumW'(in_data_i.history_index);
    if (slot_sum >= SumW'(HISTORY_DEPTH)) begin
      rd_addr = AddrW'(slot_sum - SumW'(HISTORY_DEPTH));
    end else begin
      rd_addr = slot_sum[AddrW-1:0];
    end
    hit     = 32'(in_data_i.history_index) < 32'(count_d);
    cnt_ext = 32'(count_d);
  end

  // History RAM write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) hist_mem[wr_addr] <= wr_data;
  end

  // History RAM read port, forwarding a write to the same entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (wr_en && wr_addr == rd_addr) rd_q <= wr_data;
      else rd_q <= hist_mem[rd_addr];
    end
  end

  // Timer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= bbl_pkg::MODE_READY;
      lap_start_q     <= '0;
      lap_end_q       <= '0;
      disp_start_q    <= '0;
      restored_q      <= 1'b1;
      armed_q         <= 1'b0;
      restore_start_q <= '0;
      head_q          <= '0;
      count_q         <= '0;
    end else if (accept) begin
      mode_q          <= mode_d;
      lap_start_q     <= lap_start_d;
      lap_end_q       <= lap_end_d;
      disp_start_q    <= disp_start_d;
      restored_q      <= restored_d;
      armed_q         <= armed_d;
      restore_start_q <= restore_start_d;
      head_q          <= head_d;
      count_q         <= count_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q     <= mode_d;
      broken_q <= broken;
      prog_q   <= (mode_d != bbl_pkg::MODE_READY);
      live_q   <= live;
      fin_q    <= stop;
      lap_q    <= lap;
      hcnt_q   <= cnt_ext[4:0];
      hit_q    <= hit;
    end
  end

  assign out_valid_o                 = out_valid_q;
  assign out_data_o.timer_state      = st_q;
  assign out_data_o.beam_broken      = broken_q;
  assign out_data_o.in_progress      = prog_q;
  assign out_data_o.live_time_us     = live_q;
  assign out_data_o.lap_finished     = fin_q;
  assign out_data_o.lap_time_us      = lap_q;
  assign out_data_o.history_count    = hcnt_q;
  assign out_data_o.history_lap_us   = hit_q ? rd_q[63:32] : 32'd0;
  assign out_data_o.history_stamp_ms = hit_q ? rd_q[31:0] : 32'd0;

endmodule
